>>> sv/stlb_pkg.sv
// Shared types, codes and widths for the sorted-table lower-bound search unit.
package stlb_pkg;

  localparam int DATA_W          = 32;
  localparam int FUNC_W          = 2;
  localparam int STAT_W          = 2;
  localparam int POS_W           = 10;
  localparam int TABLE_DEPTH_DEF = 1024;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // result handed from the sequencer to the output stage
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
  } res_t;

endpackage

>>> sv/stlb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module stlb_ram #(
  parameter int WIDTH = stlb_pkg::DATA_W,
  parameter int DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/stlb_ctrl.sv
// Sequencer: entry count, append/clear handling and the halving search over the RAM.
module stlb_ctrl #(
  parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [stlb_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [stlb_pkg::DATA_W-1:0]  in_operand_value,
  output logic                                in_stall,
  input  logic                                res_take,
  output stlb_pkg::res_t                      res,
  output logic                                ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr,
  output logic [stlb_pkg::DATA_W-1:0]         ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr,
  input  logic [stlb_pkg::DATA_W-1:0]         ram_rdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = stlb_pkg::POS_W;
  localparam int SW    = stlb_pkg::STAT_W;
  localparam int DW    = stlb_pkg::DATA_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_HOLD   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;    // exclusive upper bound
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [SW-1:0]        pend_status_r, pend_status_nxt;
  logic [PW-1:0]        pend_pos_r, pend_pos_nxt;

  logic             full;
  logic             probe_ge;
  logic [CNT_W-1:0] mid0;
  logic [CNT_W-1:0] span_h, mid_h, lo_m, span_m, mid_m;
  logic             nonempty_h, nonempty_m;
  logic             go;
  logic [CNT_W-1:0] nmid;
  logic             fin;
  logic [SW-1:0]    fin_status;
  logic [PW-1:0]    fin_pos;

  assign in_stall = (state_r != S_IDLE);
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign probe_ge = ($signed(ram_rdata) >= key_r);
  assign mid0     = (count_r - CNT_W'(1)) >> 1;

  // both outcomes of the current probe precomputed in parallel with the RAM read
  assign nonempty_h = (lo_r < mid_r);
  assign span_h     = mid_r - lo_r - CNT_W'(1);
  assign mid_h      = lo_r + (span_h >> 1);
  assign lo_m       = mid_r + CNT_W'(1);
  assign nonempty_m = (lo_m < hi_r);
  assign span_m     = hi_r - lo_m - CNT_W'(1);
  assign mid_m      = lo_m + (span_m >> 1);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    key_nxt         = key_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    found_nxt       = found_r;
    hit_idx_nxt     = hit_idx_r;
    pend_status_nxt = pend_status_r;
    pend_pos_nxt    = pend_pos_r;
    ram_we          = 1'b0;
    ram_waddr       = IDX_W'(count_r);
    ram_wdata       = in_operand_value;
    ram_raddr       = IDX_W'(mid0);
    go              = 1'b0;
    nmid            = mid_h;
    fin             = 1'b0;
    fin_status      = stlb_pkg::ST_OK;
    fin_pos         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            stlb_pkg::FUNC_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_status = stlb_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                fin_pos   = PW'(count_r);
              end
            end
            stlb_pkg::FUNC_QUERY: begin
              key_nxt = in_operand_value;
              if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = stlb_pkg::ST_NOT_FOUND;
              end else begin
                lo_nxt    = '0;
                hi_nxt    = count_r;
                mid_nxt   = mid0;
                found_nxt = 1'b0;
                state_nxt = S_SEARCH;
              end
            end
            stlb_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // ram_rdata holds the entry at mid_r
        if (probe_ge) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = mid_r;
          hi_nxt      = mid_r;
          go          = nonempty_h;
          nmid        = mid_h;
        end else begin
          lo_nxt = lo_m;
          go     = nonempty_m;
          nmid   = mid_m;
        end
        ram_raddr = IDX_W'(nmid);
        mid_nxt   = nmid;
        if (!go) begin
          fin = 1'b1;
          if (probe_ge) begin
            fin_pos = PW'(mid_r);
          end else if (found_r) begin
            fin_pos = PW'(hit_idx_r);
          end else begin
            fin_status = stlb_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_HOLD: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // finished result goes to the output stage now, or waits in HOLD
    if (fin) begin
      pend_status_nxt = fin_status;
      pend_pos_nxt    = fin_pos;
      state_nxt       = res_take ? S_IDLE : S_HOLD;
    end
  end

  always_comb begin
    if (fin) begin
      res = '{valid: 1'b1, status: fin_status, position: fin_pos};
    end else begin
      res = '{valid: (state_r == S_HOLD), status: pend_status_r, position: pend_pos_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    found_r       <= found_nxt;
    hit_idx_r     <= hit_idx_nxt;
    pend_status_r <= pend_status_nxt;
    pend_pos_r    <= pend_pos_nxt;
  end

endmodule

>>> sv/sorted_table_lower_bound_search_unit.sv
// Sorted-table lower-bound search unit: table RAM, search sequencer and output register.
// Append, clear and unused codes finish in IDLE. A query runs k probes, k at most
// floor(log2(count)) + 1 (11 for 1024 entries), one RAM read per probe. A result waits in
// HOLD until the output register takes it; the next item is accepted after that.
// Reset (rst_n low, synchronous) empties the table and clears the handshake; RAM not cleared.
module sorted_table_lower_bound_search_unit #(
  parameter int TABLE_DEPTH = stlb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [stlb_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [stlb_pkg::DATA_W-1:0]  in_operand_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [stlb_pkg::STAT_W-1:0]         out_status,
  output logic [stlb_pkg::POS_W-1:0]          out_position
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int DW    = stlb_pkg::DATA_W;

  // RAM port wiring
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [DW-1:0]    ram_rdata;

  // sequencer result and output register
  stlb_pkg::res_t                 res;
  logic                           res_take;
  logic                           out_valid_r;
  logic [stlb_pkg::STAT_W-1:0]    out_status_r;
  logic [stlb_pkg::POS_W-1:0]     out_position_r;

  // Entry store. A write and a useful read never overlap: appends are written
  // only while no search is in flight, so no forwarding is needed.
  stlb_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stlb_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_func          (in_func),
    .in_operand_value (in_operand_value),
    .in_stall         (in_stall),
    .res_take         (res_take),
    .res              (res),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  // Output register loads whenever it is empty or its current transfer completes;
  // a query can run in the sequencer while an older result sits here under stall.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_status_r   <= res.status;
      out_position_r <= res.position;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

`ifndef SYNTHESIS
  // only successful transfers carry a nonzero position
  a_pos_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == stlb_pkg::ST_OK || out_position == '0))
    else $error("nonzero position with non-ok status");

  // sequencer offers a result only on an input transfer or while busy
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (in_stall || in_valid))
    else $error("result offered with no item in flight");

  // a result not taken is kept for the next cycle
  a_res_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_take) |=> (res.valid && $stable(res.status) && $stable(res.position)))
    else $error("pending result dropped or changed");
`endif

endmodule
